>>> design/mm_pkg.sv
// Shared types, field widths and codes for the fixed-point matrix multiplier.
// No dependencies; every design file imports this package.
package mm_pkg;

    // Default sizing handed to the top-level parameters
    localparam int MM_MAX_DIM   = 8;
    localparam int MM_FRAC_BITS = 16;

    // Field widths of the stream items
    localparam int KIND_W     = 2;
    localparam int COORD_W    = 3;
    localparam int VAL_W      = 32;
    localparam int DIM_W      = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int IN_FIELDS_W  = 2 * COORD_W + VAL_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_W + VAL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Input item kinds; the fourth code is ignored
    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Saturation limits of the result
    localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

    // Result coordinate travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } tag_t;

    // Element load broadcast to every cell
    typedef struct packed {
        logic               we_a;
        logic               we_b;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VAL_W-1:0]   data;
    } load_t;

endpackage

>>> design/mm_cell.sv
// One multiply-accumulate cell of the chain: holds column k of A and row k of B.
// Depends on mm_pkg.
module mm_cell
    import mm_pkg::*;
#(
    parameter int MAX_DIM  = MM_MAX_DIM,
    parameter int CELL_IDX = 0,
    parameter int ACC_W    = 2 * VAL_W + 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  load_t                   load,
    input  logic [DIM_W-1:0]        inner_dim,
    input  tag_t                    tag_in,
    input  logic signed [ACC_W-1:0] sum_in,
    output tag_t                    tag_out,
    output logic signed [ACC_W-1:0] sum_out
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [VAL_W-1:0] a_mem [MAX_DIM];
    logic [VAL_W-1:0] b_mem [MAX_DIM];

    logic signed [VAL_W-1:0]   a_rd_reg;
    logic signed [VAL_W-1:0]   b_rd_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   sum1_reg;
    logic signed [ACC_W-1:0]   sum2_reg;
    logic signed [ACC_W-1:0]   sum3_reg;
    tag_t                      tag1_reg;
    tag_t                      tag2_reg;
    tag_t                      tag3_reg;
    logic                      cell_on;

    // Cells past the inner size add nothing
    assign cell_on = (DIM_W'(CELL_IDX) < inner_dim);

    // Store loads aimed at this cell's column of A or row of B
    always_ff @(posedge clk)
    begin
        if (load.we_a && load.col == COORD_W'(CELL_IDX))
        begin
            a_mem[load.row[IDX_W-1:0]] <= load.data;
        end
        if (load.we_b && load.row == COORD_W'(CELL_IDX))
        begin
            b_mem[load.col[IDX_W-1:0]] <= load.data;
        end
    end

    // Advance the coordinate tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (advance)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Read operands, multiply, then add into the passing sum
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_rd_reg <= a_mem[tag_in.row[IDX_W-1:0]];
            b_rd_reg <= b_mem[tag_in.col[IDX_W-1:0]];
            sum1_reg <= sum_in;
            prod_reg <= cell_on ? a_rd_reg * b_rd_reg : (2*VAL_W)'(0);
            sum2_reg <= sum1_reg;
            sum3_reg <= sum2_reg + ACC_W'(prod_reg);
        end
    end

    assign tag_out = tag3_reg;
    assign sum_out = sum3_reg;

endmodule

>>> design/mm_out.sv
// Output stage: scales the finished sum, saturates it and holds the result transaction.
// Depends on mm_pkg.
module mm_out
    import mm_pkg::*;
#(
    parameter int FRAC_BITS = MM_FRAC_BITS,
    parameter int ACC_W     = 2 * VAL_W + 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tag_t                    tag_in,
    input  logic signed [ACC_W-1:0] sum_in,
    output logic                    advance,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-VAL_W:0]      upper;
    logic                      fits;
    logic [VAL_W-1:0]          value;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic                      m_tuser_reg;
    logic                      m_tlast_reg;

    // Drop the fraction bits and clip to the 32-bit range
    always_comb
    begin
        shifted = sum_in >>> FRAC_BITS;
        upper   = shifted[ACC_W-1:VAL_W-1];
        fits    = (&upper) || !(|upper);
        if (fits)
        begin
            value = shifted[VAL_W-1:0];
        end
        else
        begin
            value = sum_in[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // The whole chain moves only when the output register can take a result
    assign advance = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= OUT_DATA_W'({value, tag_in.col, tag_in.row});
            m_tuser_reg <= !fits;
            m_tlast_reg <= tag_in.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> design/matrix_multiply.sv
// Top level of the fixed-point matrix multiplier: sequencer, cell chain, output stage.
// Depends on mm_pkg, mm_cell and mm_out.
//
//  channel  direction  signals                               use
//  s_*      in         s_tvalid s_tready s_tdata s_tuser     element loads and start
//  m_*      out        m_tvalid m_tready m_tdata m_tuser     result elements of C
//                      m_tlast
//  cfg_*    in         cfg_we cfg_index cfg_data             dimension registers
//
// Loads are taken back to back while the block is idle.
// A start issues one result element per cycle, unless m_tready stalls the chain, into
// a chain of MAX_DIM cells, each three stages deep, then the output register;
// s_tready stays low from the start until the final result is taken.
// A stalled m_tready freezes the whole chain; nothing is dropped.
// Reset clears control state only; matrix entries are undefined until loaded.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MM_MAX_DIM,
    parameter int FRAC_BITS = MM_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row[2:0], col[5:3], element_value[37:6]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6]
    output logic                  m_tuser,   // saturated[0]
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);

    localparam int ACC_W = 2 * VAL_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] r_reg, r_next;
    logic [COORD_W-1:0] c_reg, c_next;
    logic [DIM_W-1:0]   m_reg, m_next;
    logic [DIM_W-1:0]   n_reg, n_next;
    logic [DIM_W-1:0]   p_reg, p_next;
    logic [DIM_W-1:0]   rows_a_reg;
    logic [DIM_W-1:0]   inner_size_reg;
    logic [DIM_W-1:0]   cols_b_reg;

    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic [VAL_W-1:0]   in_val;
    logic               in_range;
    logic               s_accept;
    logic               start;
    logic               r_last;
    logic               c_last;
    logic               advance;
    logic               out_done;
    load_t              load;

    tag_t                    tag_chain [MAX_DIM+1];
    logic signed [ACC_W-1:0] sum_chain [MAX_DIM+1];

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0)
            begin
                res = DIM_W'(1);
            end
            else if (v > DIM_W'(MAX_DIM))
            begin
                res = DIM_W'(MAX_DIM);
            end
            else
            begin
                res = v;
            end
            return res;
        end
    endfunction

    // Unpack the input transaction
    assign in_row   = s_tdata[COORD_W-1:0];
    assign in_col   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_val   = s_tdata[2*COORD_W +: VAL_W];
    assign in_range = ({1'b0, in_row} < (COORD_W+1)'(MAX_DIM))
                   && ({1'b0, in_col} < (COORD_W+1)'(MAX_DIM));
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign start    = s_accept && (s_tuser == KIND_START);
    assign out_done = m_tvalid && m_tready && m_tlast;

    // Broadcast loads to the cells
    always_comb
    begin
        load.we_a = s_accept && (s_tuser == KIND_LOAD_A) && in_range;
        load.we_b = s_accept && (s_tuser == KIND_LOAD_B) && in_range;
        load.row  = in_row;
        load.col  = in_col;
        load.data = in_val;
    end

    // Hold the dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg     <= DIM_RESET;
            inner_size_reg <= DIM_RESET;
            cols_b_reg     <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS_A:     rows_a_reg     <= cfg_data;
                CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                CFG_COLS_B:     cols_b_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Issue coordinates in row-major order
    assign r_last = (DIM_W'(r_reg) == m_reg - DIM_W'(1));
    assign c_last = (DIM_W'(c_reg) == p_reg - DIM_W'(1));

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    r_next     = '0;
                    c_next     = '0;
                    m_next     = clamp_dim(rows_a_reg);
                    n_next     = clamp_dim(inner_size_reg);
                    p_next     = clamp_dim(cols_b_reg);
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    if (c_last)
                    begin
                        c_next = '0;
                        if (r_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            r_next = r_reg + COORD_W'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + COORD_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            m_reg     <= DIM_W'(1);
            n_reg     <= DIM_W'(1);
            p_reg     <= DIM_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            m_reg     <= m_next;
            n_reg     <= n_next;
            p_reg     <= p_next;
        end
    end

    // Head of the chain: current coordinate and an empty sum
    always_comb
    begin
        tag_chain[0].valid = (state_reg == ST_RUN);
        tag_chain[0].row   = r_reg;
        tag_chain[0].col   = c_reg;
        tag_chain[0].last  = r_last && c_last;
        sum_chain[0]       = '0;
    end

    // Chain of multiply-accumulate cells, one per inner index
    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        mm_cell #(
            .MAX_DIM  (MAX_DIM),
            .CELL_IDX (k),
            .ACC_W    (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .load      (load),
            .inner_dim (n_reg),
            .tag_in    (tag_chain[k]),
            .sum_in    (sum_chain[k]),
            .tag_out   (tag_chain[k+1]),
            .sum_out   (sum_chain[k+1])
        );
    end

    mm_out #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag_chain[MAX_DIM]),
        .sum_in   (sum_chain[MAX_DIM]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // No result may be pending while new input is taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("result pending while input is open");

    // Input closes right after a start
    a_start_closes: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("input still open after start");

    // Input reopens once the final result is taken
    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        out_done |=> s_tready)
        else $error("input not reopened after final result");

    // The final result sits at the last row and column
    a_last_coord: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            ((DIM_W'(m_tdata[COORD_W-1:0]) == m_reg - DIM_W'(1))
          && (DIM_W'(m_tdata[2*COORD_W-1:COORD_W]) == p_reg - DIM_W'(1))))
        else $error("final result at wrong coordinate");

endmodule
